// ----- hw/rtl/sfs_pkg.sv -----
`default_nettype none

package sfs_pkg;

    // Clip table size and derived widths
    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

    // Fixed field widths
    localparam int MODE_W     = 2;
    localparam int IN_SLOT_W  = 4;
    localparam int FRAME_W    = 10;
    localparam int DUR_W      = 16;
    localparam int DELTA_W    = 20;
    localparam int FIDX_W     = 11;
    localparam int POS_W      = 4;
    localparam int FCOUNT_W   = 5;
    localparam int ELAPSED_W  = 32;

    // Time arithmetic: duration in ms times 1000 fits in PROD_W bits
    localparam int PROD_W     = DUR_W + 10;
    localparam int ACC_W      = PROD_W + SLOT_W;
    localparam int CMP_W      = (ACC_W > ELAPSED_W) ? ACC_W : ELAPSED_W;
    localparam int MODCNT_W   = $clog2(ELAPSED_W);

    // Slot table entry: atlas frame above duration
    localparam int ENTRY_W    = FRAME_W + DUR_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_MOD,
        ST_SHOW_RD,
        ST_SHOW_WR,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic start_empty;
        logic start_run;
        logic tick_add;
        logic walk_next;
        logic walk_hit;
        logic walk_miss_end;
        logic walk_miss_zero;
        logic mod_init;
        logic mod_step;
        logic rd_show;
        logic show_wr;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  start_ok;
        logic  n_zero;
        logic  running;
        logic  hit;
        logic  last;
        logic  loop_on;
        logic  total_zero;
        logic  second;
        logic  mod_last;
        logic  out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sprite_frame_sequencer.sv -----
`default_nettype none

// Sprite animation frame sequencer. Load beats (mode 0) fill the 16-slot clip
// table with an atlas frame and a duration in ms, start beats (mode 1) rewind
// the clip unless a running clip has not finished, tick beats (mode 2) on a
// running clip add delta_us and select the first slot whose cumulative end lies
// beyond the elapsed time; every input beat returns one result beat with the
// frame shown, its slot and the finished flag. A tick walks the slot table
// through its single registered read port. A looping tick that runs past the
// clip end uses the bit-serial remainder unit plus a second walk. A new input
// beat is taken while a result waits at m_valid.
// Configuration writes are taken at any time but belong to idle periods.
module sprite_frame_sequencer
    import sfs_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [MODE_W-1:0]        s_mode,
    input  wire logic [IN_SLOT_W-1:0]     s_slot,
    input  wire logic [FRAME_W-1:0]       s_atlas_frame,
    input  wire logic [DUR_W-1:0]         s_duration_ms,
    input  wire logic [DELTA_W-1:0]       s_delta_us,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [FIDX_W-1:0]      m_frame_index,
    output logic [POS_W-1:0]              m_clip_position,
    output logic                          m_finished,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    sfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    sfs_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .s_mode          (s_mode),
        .s_slot          (s_slot),
        .s_atlas_frame   (s_atlas_frame),
        .s_duration_ms   (s_duration_ms),
        .s_delta_us      (s_delta_us),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_frame_index   (m_frame_index),
        .m_clip_position (m_clip_position),
        .m_finished      (m_finished)
    );

    // One item in flight: after an input beat the block stays busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item was still in flight");

    // An empty-clip display always points at slot zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_index[FIDX_W-1] |-> m_clip_position == '0)
        else $error("negative frame index with nonzero clip position");

    // A result is loaded only when the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid || m_ready)
        else $error("result beat overwritten before it was taken");

endmodule

`default_nettype wire

// ----- hw/rtl/sfs_ram.sv -----
`default_nettype none

module sfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sfs_ctrl.sv -----
`default_nettype none

module sfs_ctrl
    import sfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (st.mode)
                    MODE_START: begin
                        if (st.start_ok && !st.n_zero) begin
                            state_next = ST_SHOW_RD;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                    MODE_TICK: begin
                        if (st.running && !st.n_zero) begin
                            state_next = ST_WALK_RD;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_WALK_RD: state_next = ST_WALK_CMP;
            ST_WALK_CMP: begin
                if (st.hit) begin
                    state_next = ST_SHOW_RD;
                end else if (!st.last) begin
                    state_next = ST_WALK_RD;
                end else if (!st.loop_on || st.second || st.total_zero) begin
                    state_next = ST_SHOW_RD;
                end else begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (st.mod_last) begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_SHOW_RD: state_next = ST_SHOW_WR;
            ST_SHOW_WR: state_next = ST_FINISH;
            ST_FINISH: begin
                if (!st.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                unique case (st.mode)
                    MODE_LOAD:  cmd.load_wr = 1'b1;
                    MODE_START: begin
                        cmd.start_empty = st.start_ok && st.n_zero;
                        cmd.start_run   = st.start_ok && !st.n_zero;
                    end
                    MODE_TICK:  cmd.tick_add = st.running && !st.n_zero;
                    default: ;
                endcase
            end
            ST_WALK_RD: ;
            ST_WALK_CMP: begin
                if (st.hit) begin
                    cmd.walk_hit = 1'b1;
                end else if (!st.last) begin
                    cmd.walk_next = 1'b1;
                end else if (!st.loop_on || st.second) begin
                    cmd.walk_miss_end = 1'b1;
                end else if (st.total_zero) begin
                    cmd.walk_miss_zero = 1'b1;
                end else begin
                    cmd.mod_init = 1'b1;
                end
            end
            ST_MOD:     cmd.mod_step = 1'b1;
            ST_SHOW_RD: cmd.rd_show  = 1'b1;
            ST_SHOW_WR: cmd.show_wr  = 1'b1;
            ST_FINISH:  cmd.out_load = !st.out_busy;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfs_datapath.sv -----
`default_nettype none

module sfs_datapath
    import sfs_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire dp_cmd_t                      cmd,
    output dp_status_t                        st,
    input  wire logic [MODE_W-1:0]            s_mode,
    input  wire logic [IN_SLOT_W-1:0]         s_slot,
    input  wire logic [FRAME_W-1:0]           s_atlas_frame,
    input  wire logic [DUR_W-1:0]             s_duration_ms,
    input  wire logic [DELTA_W-1:0]           s_delta_us,
    input  wire logic                         cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                         m_ready,
    output logic                              m_valid,
    output logic signed [FIDX_W-1:0]          m_frame_index,
    output logic [POS_W-1:0]                  m_clip_position,
    output logic                              m_finished
);

    // Captured input beat
    logic [MODE_W-1:0]    mode_reg;
    logic [IN_SLOT_W-1:0] slot_reg;
    logic [FRAME_W-1:0]   atlas_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [DELTA_W-1:0]   delta_reg;

    // Configuration
    logic                 loop_reg;
    logic [FCOUNT_W-1:0]  fcount_reg;

    // Clip state
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic                      done_reg, done_next;
    logic                      running_reg, running_next;
    logic signed [FIDX_W-1:0]  shown_frame_reg, shown_frame_next;
    logic [SLOT_W-1:0]         shown_slot_reg, shown_slot_next;

    // Walk and remainder unit
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]    show_idx_reg, show_idx_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     rem_reg, rem_next;
    logic [ELAPSED_W-1:0] div_reg, div_next;
    logic [MODCNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic                 second_reg, second_next;

    // Output register
    logic                      m_valid_reg;
    logic signed [FIDX_W-1:0]  m_frame_reg;
    logic [POS_W-1:0]          m_pos_reg;
    logic                      m_fin_reg;

    // Slot table
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [FRAME_W-1:0]   rd_atlas;
    logic [DUR_W-1:0]     rd_dur;

    // Derived values
    logic [CNT_W-1:0]     n_slots;
    logic [SLOT_W-1:0]    n_last;
    logic [PROD_W-1:0]    dur_prod;
    logic [ACC_W-1:0]     acc_sum;
    logic [ELAPSED_W:0]   add_sum;
    logic [ACC_W:0]       trial;
    logic                 trial_ge;

    assign ram_we    = cmd.load_wr && (32'(slot_reg) < MAX_SLOTS);
    assign ram_waddr = SLOT_W'(slot_reg);
    assign ram_raddr = cmd.rd_show ? show_idx_reg : idx_reg;

    sfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({atlas_reg, dur_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_atlas = ram_rdata[ENTRY_W-1:DUR_W];
    assign rd_dur   = ram_rdata[DUR_W-1:0];

    // Clamp slot count to the table size
    assign n_slots = (32'(fcount_reg) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(fcount_reg);
    assign n_last  = SLOT_W'(n_slots - CNT_W'(1));

    // Slot end in microseconds: ms * 1000 = ms * 1024 - ms * 16 - ms * 8
    assign dur_prod = (PROD_W'(rd_dur) << 10) - (PROD_W'(rd_dur) << 4)
                    - (PROD_W'(rd_dur) << 3);
    assign acc_sum  = acc_reg + ACC_W'(dur_prod);

    // Saturating elapsed-time add
    assign add_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(delta_reg);

    // One restoring remainder step, divisor held in acc_reg
    assign trial    = {rem_reg, div_reg[ELAPSED_W-1]};
    assign trial_ge = trial >= {1'b0, acc_reg};

    // Status toward the controller
    always_comb begin
        st.mode       = mode_t'(mode_reg);
        st.start_ok   = !(running_reg && !done_reg);
        st.n_zero     = (n_slots == '0);
        st.running    = running_reg;
        st.hit        = CMP_W'(elapsed_reg) < CMP_W'(acc_sum);
        st.last       = (idx_reg == n_last);
        st.loop_on    = loop_reg;
        st.total_zero = (acc_sum == '0);
        st.second     = second_reg;
        st.mod_last   = (bit_cnt_reg == MODCNT_W'(ELAPSED_W - 1));
        st.out_busy   = m_valid_reg && !m_ready;
    end

    // Next values of the clip state and walk registers
    always_comb begin
        elapsed_next     = elapsed_reg;
        done_next        = done_reg;
        running_next     = running_reg;
        shown_frame_next = shown_frame_reg;
        shown_slot_next  = shown_slot_reg;
        idx_next         = idx_reg;
        show_idx_next    = show_idx_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        bit_cnt_next     = bit_cnt_reg;
        second_next      = second_reg;

        // Rewind the clip
        if (cmd.start_empty) begin
            elapsed_next     = '0;
            shown_frame_next = '1;
            shown_slot_next  = '0;
            done_next        = 1'b1;
            running_next     = 1'b0;
        end
        if (cmd.start_run) begin
            elapsed_next  = '0;
            done_next     = 1'b0;
            running_next  = 1'b1;
            show_idx_next = '0;
        end

        // Advance time and start the slot walk
        if (cmd.tick_add) begin
            elapsed_next = add_sum[ELAPSED_W] ? '1 : add_sum[ELAPSED_W-1:0];
            acc_next     = '0;
            idx_next     = '0;
            second_next  = 1'b0;
        end

        // Walk decisions
        if (cmd.walk_next) begin
            acc_next = acc_sum;
            idx_next = idx_reg + SLOT_W'(1);
        end
        if (cmd.walk_hit) begin
            show_idx_next = idx_reg;
            if (loop_reg) begin
                done_next = 1'b0;
            end
        end
        if (cmd.walk_miss_end) begin
            show_idx_next = n_last;
            done_next     = !loop_reg;
        end
        if (cmd.walk_miss_zero) begin
            show_idx_next = '0;
            done_next     = 1'b0;
        end

        // Wrap elapsed time modulo the clip total
        if (cmd.mod_init) begin
            acc_next     = acc_sum;
            div_next     = elapsed_reg;
            rem_next     = '0;
            bit_cnt_next = '0;
            second_next  = 1'b1;
        end
        if (cmd.mod_step) begin
            rem_next     = trial_ge ? ACC_W'(trial - {1'b0, acc_reg}) : ACC_W'(trial);
            div_next     = div_reg << 1;
            bit_cnt_next = bit_cnt_reg + MODCNT_W'(1);
            if (st.mod_last) begin
                elapsed_next = ELAPSED_W'(rem_next);
                acc_next     = '0;
                idx_next     = '0;
            end
        end

        // Show the chosen slot
        if (cmd.show_wr) begin
            shown_frame_next = $signed({1'b0, rd_atlas});
            shown_slot_next  = show_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_reg        <= 1'b1;
            fcount_reg      <= '0;
            elapsed_reg     <= '0;
            done_reg        <= 1'b0;
            running_reg     <= 1'b0;
            shown_frame_reg <= '1;
            shown_slot_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_LOOP_ENABLE: loop_reg   <= cfg_data[0];
                    CFG_FRAME_COUNT: fcount_reg <= cfg_data[FCOUNT_W-1:0];
                    default: ;
                endcase
            end
            elapsed_reg     <= elapsed_next;
            done_reg        <= done_next;
            running_reg     <= running_next;
            shown_frame_reg <= shown_frame_next;
            shown_slot_reg  <= shown_slot_next;
            // Output beat handshake
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_mode;
            slot_reg  <= s_slot;
            atlas_reg <= s_atlas_frame;
            dur_reg   <= s_duration_ms;
            delta_reg <= s_delta_us;
        end
        idx_reg      <= idx_next;
        show_idx_reg <= show_idx_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        bit_cnt_reg  <= bit_cnt_next;
        second_reg   <= second_next;
        if (cmd.out_load) begin
            m_frame_reg <= shown_frame_reg;
            m_pos_reg   <= POS_W'(shown_slot_reg);
            m_fin_reg   <= done_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_index   = m_frame_reg;
    assign m_clip_position = m_pos_reg;
    assign m_finished      = m_fin_reg;

endmodule

`default_nettype wire
